/* design/bchd_pkg.sv */
package bchd_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned HOLD_W     = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned EVT_W      = 2;
    localparam int unsigned S_DATA_W   = 40;
    localparam int unsigned M_DATA_W   = 8;

    // event codes
    localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVT_W-1:0] EVT_CLICK = 2'd1;
    localparam logic [EVT_W-1:0] EVT_HOLD  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic [GAP_W-1:0]      GAP_RST      = 16'd280;
    localparam logic [HOLD_W-1:0]     HOLD_RST     = 20'd10000;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [GAP_W-1:0]      double_click_gap_ms;
        logic [HOLD_W-1:0]     hold_time_ms;
    } cfg_t;

    typedef struct packed {
        logic              previous_level;
        logic              waiting_for_second;
        logic              second_click_pending;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] release_time;
        logic              ignore_release;
        logic              hold_reported;
    } btn_state_t;

    localparam btn_state_t STATE_RST = '{
        previous_level:       1'b1,
        waiting_for_second:   1'b0,
        second_click_pending: 1'b0,
        press_time:           '1,
        release_time:         '1,
        ignore_release:       1'b0,
        hold_reported:        1'b0
    };

endpackage

/* design/bchd_eval.sv */
module bchd_eval (
    input  bchd_pkg::cfg_t                  cfg,
    input  bchd_pkg::btn_state_t            state_cur,
    input  logic                            level,
    input  logic [bchd_pkg::TIME_W-1:0]     now_ms,
    output bchd_pkg::btn_state_t            state_next,
    output logic [bchd_pkg::EVT_W-1:0]      click_event
);

    logic [bchd_pkg::TIME_W-1:0] since_release;
    logic [bchd_pkg::TIME_W-1:0] since_press;
    logic [bchd_pkg::TIME_W-1:0] click_age;
    logic [bchd_pkg::TIME_W-1:0] hold_age;
    logic [bchd_pkg::TIME_W-1:0] debounce_ext;
    logic [bchd_pkg::TIME_W-1:0] gap_ext;
    logic [bchd_pkg::TIME_W-1:0] hold_ext;
    logic press_acc;
    logic release_acc;
    logic release_upd;
    logic do_click;
    logic do_hold;
    bchd_pkg::btn_state_t mid;

    assign debounce_ext  = {{(bchd_pkg::TIME_W-bchd_pkg::DEBOUNCE_W){1'b0}}, cfg.debounce_ms};
    assign gap_ext       = {{(bchd_pkg::TIME_W-bchd_pkg::GAP_W){1'b0}},
                            cfg.double_click_gap_ms};
    assign hold_ext      = {{(bchd_pkg::TIME_W-bchd_pkg::HOLD_W){1'b0}}, cfg.hold_time_ms};

    assign since_release = now_ms - state_cur.release_time;
    assign since_press   = now_ms - state_cur.press_time;

    assign press_acc   = !level && state_cur.previous_level && (since_release > debounce_ext);
    assign release_acc = level && !state_cur.previous_level && (since_press > debounce_ext);
    assign release_upd = release_acc && !state_cur.ignore_release;

    // a timestamp just taken is "now", so its age is zero
    assign click_age = release_upd ? '0 : since_release;
    assign hold_age  = press_acc ? '0 : since_press;

    always_comb begin
        mid = state_cur;
        mid.previous_level = level;
        if (press_acc) begin
            mid.press_time           = now_ms;
            mid.ignore_release       = 1'b0;
            mid.hold_reported        = 1'b0;
            mid.second_click_pending = (since_release < gap_ext) &&
                                       !state_cur.second_click_pending &&
                                       state_cur.waiting_for_second;
            mid.waiting_for_second   = 1'b0;
        end else if (release_upd) begin
            mid.release_time = now_ms;
            if (!state_cur.second_click_pending) begin
                mid.waiting_for_second = 1'b1;
            end
        end
    end

    assign do_click = level && (click_age >= gap_ext) && mid.waiting_for_second &&
                      !mid.second_click_pending;
    assign do_hold  = !level && (hold_age >= hold_ext) && !mid.hold_reported;

    always_comb begin
        state_next  = mid;
        click_event = bchd_pkg::EVT_NONE;
        if (do_click) begin
            click_event                   = bchd_pkg::EVT_CLICK;
            state_next.waiting_for_second = 1'b0;
        end
        if (do_hold) begin
            click_event                     = bchd_pkg::EVT_HOLD;
            state_next.ignore_release       = 1'b1;
            state_next.second_click_pending = 1'b0;
            state_next.waiting_for_second   = 1'b0;
            state_next.hold_reported        = 1'b1;
        end
    end

endmodule

/* design/button_click_hold_detector.sv */
// channel  | direction | tdata fields (low bit up)                   | tuser | tlast
// s_       | in        | button_level [0], now_ms [32:1], zero pad    | -     | -
// m_       | out       | click_event [1:0], zero pad                  | -     | -
// cfg_wr_  | in        | index 0 debounce, 1 double-click gap, 2 hold | -     | -
//
// One word per cycle sustained while m_ does not stall; a word passes from s_ to m_ through the input
// register, then one pass of compare logic that updates state and the result register.
// The per-word state loop (two 32-bit subtracts and compares) forms that pass.
// aresetn is synchronous, active low; it restores config, valid flags and state to defaults.
// A stall on m_ holds the result; s_tready stays high while the input register is
// empty or can move into the result register this cycle.
module button_click_hold_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bchd_pkg::S_DATA_W-1:0]      s_tdata,    // button_level, now_ms
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bchd_pkg::M_DATA_W-1:0]      m_tdata,    // click_event
    input  logic                               cfg_wr_en,
    input  logic [bchd_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [bchd_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    bchd_pkg::cfg_t                 cfg_reg;
    bchd_pkg::btn_state_t           state_reg;
    bchd_pkg::btn_state_t           state_next;
    logic                           in_valid_reg;
    logic                           in_level_reg;
    logic [bchd_pkg::TIME_W-1:0]    in_now_reg;
    logic                           out_valid_reg;
    logic [bchd_pkg::EVT_W-1:0]     out_event_reg;
    logic [bchd_pkg::EVT_W-1:0]     event_next;
    logic                           advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bchd_pkg::M_DATA_W-bchd_pkg::EVT_W){1'b0}}, out_event_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms         <= bchd_pkg::DEBOUNCE_RST;
            cfg_reg.double_click_gap_ms <= bchd_pkg::GAP_RST;
            cfg_reg.hold_time_ms        <= bchd_pkg::HOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                bchd_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms <=
                    cfg_wr_data[bchd_pkg::DEBOUNCE_W-1:0];
                bchd_pkg::REG_GAP:      cfg_reg.double_click_gap_ms <=
                    cfg_wr_data[bchd_pkg::GAP_W-1:0];
                bchd_pkg::REG_HOLD:     cfg_reg.hold_time_ms <=
                    cfg_wr_data[bchd_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[bchd_pkg::TIME_W:1];
        end
    end

    bchd_eval u_eval (
        .cfg         (cfg_reg),
        .state_cur   (state_reg),
        .level       (in_level_reg),
        .now_ms      (in_now_reg),
        .state_next  (state_next),
        .click_event (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bchd_pkg::STATE_RST;
            out_valid_reg <= 1'b0;
            out_event_reg <= bchd_pkg::EVT_NONE;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_event_reg <= event_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a hold is flagged only together with the hold event it produces
    a_hold_flag_with_event: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.hold_reported) |-> out_event_reg == bchd_pkg::EVT_HOLD)
        else $error("hold_reported set without a hold event");

    // the double-click window and a swallowed second click never coexist
    a_wait_pending_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.waiting_for_second && state_reg.second_click_pending))
        else $error("waiting_for_second and second_click_pending both set");

    // a buffered word moves on whenever the result register is free
    a_input_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("input word not moved into empty result register");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_event_reg == bchd_pkg::EVT_NONE ||
                           out_event_reg == bchd_pkg::EVT_CLICK ||
                           out_event_reg == bchd_pkg::EVT_HOLD))
        else $error("undefined event code on output");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam logic [bchd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it
    localparam int CYCLE_LIMIT = 200000;
    localparam int WORDS_PER_PHASE = 150;
    localparam int HOLDOFF_AT = 400;
    localparam int HOLDOFF_CYCLES = 200;

    typedef struct packed {
        logic                        lvl;
        logic [bchd_pkg::TIME_W-1:0] stamp;
        logic                        known;
        logic [bchd_pkg::EVT_W-1:0]  evt;
    } probe_row_t;

    localparam int N_DIRECTED = 18;
    // at reset settings: debounce 10, gap 280, hold 10000
    localparam probe_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, 32'd0,          1'b1, bchd_pkg::EVT_NONE},
        '{1'b0, 32'd5,          1'b0, bchd_pkg::EVT_NONE},   // press inside debounce, lost
        '{1'b0, 32'd10005,      1'b1, bchd_pkg::EVT_HOLD},   // held low from start
        '{1'b1, 32'd10100,      1'b0, bchd_pkg::EVT_NONE},   // release after hold is ignored
        '{1'b0, 32'd10200,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b1, 32'd10300,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b1, 32'd10580,      1'b1, bchd_pkg::EVT_CLICK},  // gap just expired
        '{1'b0, 32'd11000,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b1, 32'd11050,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b0, 32'd11100,      1'b0, bchd_pkg::EVT_NONE},   // second press of a double click
        '{1'b1, 32'd11150,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b1, 32'd12000,      1'b0, bchd_pkg::EVT_NONE},   // double click swallowed
        '{1'b0, 32'd12100,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b1, 32'd12105,      1'b0, bchd_pkg::EVT_NONE},   // bounce on release
        '{1'b0, 32'd12200,      1'b0, bchd_pkg::EVT_NONE},
        '{1'b0, 32'd22200,      1'b1, bchd_pkg::EVT_HOLD},
        '{1'b0, 32'hFFFF_FFFF,  1'b0, bchd_pkg::EVT_NONE},
        '{1'b1, 32'hFFFF_FFFF,  1'b0, bchd_pkg::EVT_NONE}
    };

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bchd_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bchd_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [bchd_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [bchd_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    // button model state and its copy of the registers, kept at time width
    logic [bchd_pkg::TIME_W-1:0] deb_ms;
    logic [bchd_pkg::TIME_W-1:0] gap_ms;
    logic [bchd_pkg::TIME_W-1:0] hold_ms;
    logic                        last_lvl;
    logic                        awaiting_second;
    logic                        dbl_pending;
    logic [bchd_pkg::TIME_W-1:0] prs_t;
    logic [bchd_pkg::TIME_W-1:0] rel_t;
    logic                        skip_release;
    logic                        hold_done;

    logic [bchd_pkg::EVT_W-1:0] pending_events [$];
    logic [bchd_pkg::EVT_W-1:0] want;
    int  fail_count = 0;
    int  words_sent = 0;
    int  events_seen = 0;
    int  clicks_seen = 0;
    int  holds_seen = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    bit  held_off = 1'b0;

    button_click_hold_detector DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [bchd_pkg::EVT_W-1:0] next_click_event(
        input logic lvl, input logic [bchd_pkg::TIME_W-1:0] t);
        logic [bchd_pkg::TIME_W-1:0] since_rel;
        logic [bchd_pkg::TIME_W-1:0] since_prs;
        logic [bchd_pkg::EVT_W-1:0]  evt;
        since_rel = t - rel_t;
        since_prs = t - prs_t;
        evt = bchd_pkg::EVT_NONE;
        if (!lvl && last_lvl && since_rel > deb_ms) begin
            prs_t = t;
            skip_release = 1'b0;
            hold_done = 1'b0;
            dbl_pending = (since_rel < gap_ms) && !dbl_pending && awaiting_second;
            awaiting_second = 1'b0;
        end else if (lvl && !last_lvl && since_prs > deb_ms) begin
            if (!skip_release) begin
                rel_t = t;
                if (!dbl_pending)
                    awaiting_second = 1'b1;
            end
        end
        since_rel = t - rel_t;
        since_prs = t - prs_t;
        if (lvl && since_rel >= gap_ms && awaiting_second && !dbl_pending) begin
            evt = bchd_pkg::EVT_CLICK;
            awaiting_second = 1'b0;
        end
        if (!lvl && since_prs >= hold_ms && !hold_done) begin
            evt = bchd_pkg::EVT_HOLD;
            skip_release = 1'b1;
            dbl_pending = 1'b0;
            awaiting_second = 1'b0;
            hold_done = 1'b1;
        end
        last_lvl = lvl;
        return evt;
    endfunction

    // time advance picked near the thresholds that matter
    function automatic logic [bchd_pkg::TIME_W-1:0] next_time_step();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 3);
            2, 3:    return deb_ms + $urandom_range(0, 2);
            4:       return $urandom_range(0, gap_ms);
            5, 6:    return gap_ms + $urandom_range(0, 2);
            7:       return hold_ms + $urandom_range(0, 1);
            8:       return $urandom_range(0, hold_ms);
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic offer_word(input logic lvl, input logic [bchd_pkg::TIME_W-1:0] t,
                              input logic known, input logic [bchd_pkg::EVT_W-1:0] typed);
        logic [bchd_pkg::EVT_W-1:0] evt;
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(bchd_pkg::S_DATA_W-bchd_pkg::TIME_W-1){1'b0}}, t, lvl};
        do @(posedge aclk); while (!s_tready);
        evt = next_click_event(lvl, t);
        pending_events.push_back(known ? typed : evt);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic apply_reg(input logic [bchd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bchd_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        case (idx)
            bchd_pkg::REG_DEBOUNCE: deb_ms = 32'(val[bchd_pkg::DEBOUNCE_W-1:0]);
            bchd_pkg::REG_GAP:      gap_ms = 32'(val[bchd_pkg::GAP_W-1:0]);
            bchd_pkg::REG_HOLD:     hold_ms = 32'(val[bchd_pkg::HOLD_W-1:0]);
            default: ;
        endcase
    endtask

    // upper data bits of the 16-bit registers get junk that must be masked
    task automatic configure(input logic [bchd_pkg::DEBOUNCE_W-1:0] deb,
                             input logic [bchd_pkg::GAP_W-1:0] gap,
                             input logic [bchd_pkg::HOLD_W-1:0] hold);
        logic [3:0] junk_a;
        logic [3:0] junk_b;
        junk_a = 4'($urandom_range(0, 15));
        junk_b = 4'($urandom_range(0, 15));
        apply_reg(REG_SPARE, 20'($urandom()));
        apply_reg(bchd_pkg::REG_DEBOUNCE, {junk_a, deb});
        apply_reg(bchd_pkg::REG_GAP, {junk_b, gap});
        apply_reg(bchd_pkg::REG_HOLD, hold);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // drain everything before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        logic                        lvl;
        logic [bchd_pkg::TIME_W-1:0] stamp;
        lvl = last_lvl;
        stamp = $urandom();
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 12) begin
                lvl = 1'($urandom_range(0, 1));
                stamp = $urandom();
            end else begin
                if ($urandom_range(0, 99) < 35)
                    lvl = !lvl;
                stamp = stamp + next_time_step();
            end
            offer_word(lvl, stamp, 1'b0, bchd_pkg::EVT_NONE);
        end
    endtask

    initial begin
        deb_ms = 32'(bchd_pkg::DEBOUNCE_RST);
        gap_ms = 32'(bchd_pkg::GAP_RST);
        hold_ms = 32'(bchd_pkg::HOLD_RST);
        last_lvl = 1'b1;
        awaiting_second = 1'b0;
        dbl_pending = 1'b0;
        prs_t = '1;
        rel_t = '1;
        skip_release = 1'b0;
        hold_done = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            offer_word(DIRECTED_ROWS[i].lvl, DIRECTED_ROWS[i].stamp,
                       DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].evt);

        settle(); configure(16'd10, 16'd280, 20'd10000);   run_random(WORDS_PER_PHASE);
        settle(); configure(16'd0, 16'd0, 20'd0);          run_random(WORDS_PER_PHASE);
        settle(); configure(16'hFFFF, 16'hFFFF, 20'hFFFFF); run_random(WORDS_PER_PHASE);
        settle(); configure(16'd3, 16'd40, 20'd200);
        calm = 1'b1;
        run_random(WORDS_PER_PHASE);
        calm = 1'b0;
        settle(); configure(16'hFFFF, 16'd0, 20'd0);       run_random(WORDS_PER_PHASE);
        settle(); configure(16'd0, 16'hFFFF, 20'hFFFFF);   run_random(WORDS_PER_PHASE);
        settle(); configure(16'd5, 16'd100, 20'd1000);     run_random(WORDS_PER_PHASE);
        settle(); configure(16'($urandom_range(0, 50)), 16'($urandom_range(0, 500)),
                            20'($urandom_range(0, 5000))); run_random(WORDS_PER_PHASE);
        settle(); configure(16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
                            20'($urandom_range(0, 2000))); run_random(WORDS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("button detector: %0d words in, %0d events out (%0d clicks, %0d holds)",
                 words_sent, events_seen, clicks_seen, holds_seen);
        $display("reset settings plus %0d register settings incl. zero and full scale",
                 settings_used);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the input
    initial begin
        forever begin
            @(negedge aclk);
            if (!held_off && events_seen >= HOLDOFF_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: word with no event pending, got %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_tdata !== {{(bchd_pkg::M_DATA_W-bchd_pkg::EVT_W){1'b0}}, want}) begin
                    $display("%0t: click_event mismatch, expected %0d got %h",
                             $time, want, m_tdata);
                    fail_count++;
                end
                events_seen++;
                if (want == bchd_pkg::EVT_CLICK)
                    clicks_seen++;
                if (want == bchd_pkg::EVT_HOLD)
                    holds_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d events still pending", $time, pending_events.size());
            $display("testbench: errors");
            $finish;
        end
    end

endmodule
